// File: rtl/oeps_pkg.sv
//------------------------------------------------------------------------------
// oeps_pkg: shared types and constants of the oldest entry prune selector
// Sizes of the sorting chain, word layouts of both channels and the cell
// control group.
//------------------------------------------------------------------------------
`default_nettype none

package oeps_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int SEQ_BITS    = 14;
	localparam int KEEP_W      = 7;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W       = ((CNT_W > KEEP_W) ? CNT_W : KEEP_W) + 1;
	localparam int VCNT_W      = 7;

	localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(32);

	typedef struct packed {
		logic [SEQ_BITS-1:0] seq_value;
		logic                last_item;
	} item_word_t;

	typedef struct packed {
		logic [SEQ_BITS-1:0] victim_seq;
		logic                has_victim;
		logic [VCNT_W-1:0]   victim_count;
		logic                last_victim;
		logic                overflow;
	} result_word_t;

	typedef struct packed {
		logic insert;
		logic shift;
		logic occupied;
		logic is_tail;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/oeps_cell.sv
//------------------------------------------------------------------------------
// oeps_cell: one place of the sorted chain
// Holds one value. On an insert it either keeps its value or takes the
// left neighbour's value or the new one; on a shift it takes the right
// neighbour's value.
//------------------------------------------------------------------------------
`default_nettype none

module oeps_cell (
	input  wire                          clk,
	input  oeps_pkg::cell_ctrl_t         ctrl,
	input  wire [oeps_pkg::SEQ_BITS-1:0] new_val,
	input  wire                          left_gt,
	input  wire [oeps_pkg::SEQ_BITS-1:0] left_val,
	input  wire [oeps_pkg::SEQ_BITS-1:0] right_val,
	output logic [oeps_pkg::SEQ_BITS-1:0] val,
	output logic                          gt
);
	import oeps_pkg::*;

	logic [SEQ_BITS-1:0] val_q;

	assign val = val_q;
	// Occupied cells above the new value move right by one place.
	assign gt  = ctrl.occupied && (val_q > new_val);

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (gt || ctrl.is_tail) begin
				val_q <= left_gt ? left_val : new_val;
			end
		end else if (ctrl.shift) begin
			val_q <= right_val;
		end
	end

endmodule

`default_nettype wire

// File: rtl/oldest_entry_prune_selector.sv
// Each loaded word is sorted into the chain at once; a full chain sets overflow instead.
// After the closing word, results follow one per cycle unless result_ready holds them back,
// max(V, 1) results for V victims, while no new word is taken.
// Throughput is set by the single output register and the left shift of the chain.
// Reset clears the count, the overflow flag, the output valid flag and sets keep to 32.
//------------------------------------------------------------------------------
// oldest_entry_prune_selector: top level
// Loads sequence numbers into a sorted chain of cells and then shifts out
// the smallest ones as prune victims.
//------------------------------------------------------------------------------
`default_nettype none

module oldest_entry_prune_selector (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      item_valid,
	output logic                     item_ready,
	input  oeps_pkg::item_word_t     item_data,
	output logic                     result_valid,
	input  wire                      result_ready,
	output oeps_pkg::result_word_t   result_data,
	input  wire                      keep_we,
	input  wire [oeps_pkg::KEEP_W-1:0] keep_wdata
);
	import oeps_pkg::*;

	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic               state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic               ovf_q;
	logic [KEEP_W-1:0]  keep_q;
	logic               res_valid_q;
	result_word_t       res_q;

	logic               accept;
	logic               full;
	logic               ins;
	logic               emit_go;
	logic               has;
	logic               last;
	logic [CMP_W-1:0]   cnt_ext;
	logic [CMP_W-1:0]   keep_ext;
	logic [CNT_W-1:0]   tot;

	logic [SEQ_BITS-1:0] cell_val [MAX_ENTRIES];
	logic                cell_gt  [MAX_ENTRIES];
	cell_ctrl_t          cell_ctl [MAX_ENTRIES];

	assign item_ready   = (state_q == ST_LOAD);
	assign accept       = item_valid && item_ready;
	assign full         = (count_q == CNT_W'(MAX_ENTRIES));
	assign ins          = accept && !full;
	assign result_valid = res_valid_q;
	assign result_data  = res_q;

	assign cnt_ext  = CMP_W'(count_q);
	assign keep_ext = CMP_W'(keep_q);
	assign tot      = (cnt_ext > keep_ext) ? CNT_W'(cnt_ext - keep_ext) : '0;
	assign has      = (tot != '0);
	assign last     = !has || (idx_q == tot - CNT_W'(1));
	assign emit_go  = (state_q == ST_EMIT) && (!res_valid_q || result_ready);

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic                lgt;
		logic [SEQ_BITS-1:0] lval;
		logic [SEQ_BITS-1:0] rval;

		if (i == 0) begin : g_first
			assign lgt  = 1'b0;
			assign lval = item_data.seq_value;
		end else begin : g_mid
			assign lgt  = cell_gt[i-1];
			assign lval = cell_val[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_lastc
			assign rval = cell_val[i];
		end else begin : g_inner
			assign rval = cell_val[i+1];
		end

		assign cell_ctl[i].insert   = ins;
		assign cell_ctl[i].shift    = emit_go && has;
		assign cell_ctl[i].occupied = (CNT_W'(i) < count_q);
		assign cell_ctl[i].is_tail  = (CNT_W'(i) == count_q);

		oeps_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctl[i]),
			.new_val   (item_data.seq_value),
			.left_gt   (lgt),
			.left_val  (lval),
			.right_val (rval),
			.val       (cell_val[i]),
			.gt        (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
		end else if (keep_we) begin
			keep_q <= keep_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			idx_q       <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (item_data.last_item) begin
							state_q <= ST_EMIT;
							idx_q   <= '0;
						end
					end
				end
				ST_EMIT: begin
					if (emit_go && last) begin
						state_q <= ST_LOAD;
						count_q <= '0;
						ovf_q   <= 1'b0;
						idx_q   <= '0;
					end else if (emit_go) begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase

			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// The smallest remaining value always sits in the first cell.
	always_ff @(posedge clk) begin
		if (emit_go) begin
			res_q.victim_seq   <= has ? cell_val[0] : '0;
			res_q.has_victim   <= has;
			res_q.victim_count <= VCNT_W'(tot);
			res_q.last_victim  <= last;
			res_q.overflow     <= ovf_q;
		end
	end

endmodule

`default_nettype wire
